### hdl/cafp_pkg.sv
// Shared types, constants and byte classification for the ASCII command frame parser.
// No dependencies; every other file of the parser imports this package.
package cafp_pkg;

   // payload bytes kept per frame, plus the string terminator slot
   localparam int BUFFER_BYTES = 32;
   localparam int CntW         = $clog2(BUFFER_BYTES);
   localparam logic [CntW-1:0] PayloadLimit = CntW'(BUFFER_BYTES - 1);

   localparam int FieldW  = 16;
   localparam int FoundW  = 3;
   localparam int NumVals = 5;
   localparam int NumKept = 4;
   localparam logic [FoundW-1:0] MaxFields = FoundW'(NumVals);
   localparam logic [FoundW-1:0] LastKept  = FoundW'(NumKept - 1);

   localparam int CsrIdxW = 8;
   localparam logic [CsrIdxW-1:0] CSR_START_MARKER = 8'd0;
   localparam logic [CsrIdxW-1:0] CSR_END_MARKER   = 8'd1;
   localparam logic [7:0] START_MARKER_RST = 8'h3E;
   localparam logic [7:0] END_MARKER_RST   = 8'h3C;

   localparam logic [7:0] CHR_COLON = 8'h3A;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_ZERO  = 8'h30;

   localparam int CmdDepth = 4;
   localparam int CmdPtrW  = $clog2(CmdDepth);
   localparam int RspDepth = 2;
   localparam int RspPtrW  = $clog2(RspDepth);

   typedef enum logic [2:0] {
      CLS_NUL   = 3'd0,
      CLS_COLON = 3'd1,
      CLS_SPACE = 3'd2,
      CLS_PLUS  = 3'd3,
      CLS_MINUS = 3'd4,
      CLS_DIGIT = 3'd5,
      CLS_OTHER = 3'd6
   } byte_class_type;

   typedef enum logic [2:0] {
      PH_SKIP   = 3'b001,
      PH_DIGITS = 3'b010,
      PH_DONE   = 3'b100
   } phase_type;

   typedef struct packed {
      logic           is_close;
      byte_class_type cls;
      logic [3:0]     digit;
   } cmd_type;

   typedef struct packed {
      logic signed [FieldW-1:0] module_code;
      logic signed [FieldW-1:0] op_code;
      logic signed [FieldW-1:0] arg_one;
      logic signed [FieldW-1:0] arg_two;
      logic signed [FieldW-1:0] arg_three;
      logic [FoundW-1:0]        fields_found;
   } rsp_type;

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type c;
      c = CLS_OTHER;
      if (b == 8'h00) c = CLS_NUL;
      else if (b == CHR_COLON) c = CLS_COLON;
      else if (b == CHR_PLUS) c = CLS_PLUS;
      else if (b == CHR_MINUS) c = CLS_MINUS;
      else if (b inside {8'h20, [8'h09:8'h0D]}) c = CLS_SPACE;
      else if (b inside {[8'h30:8'h39]}) c = CLS_DIGIT;
      return c;
   endfunction

endpackage

### hdl/cafp_cmd_fifo.sv
// Four-word queue of classified payload words between front and back.
// Depends on cafp_pkg.
module cafp_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  cafp_pkg::cmd_type wr_cmd,
   output logic              full,
   input  logic              rd_en,
   output cafp_pkg::cmd_type rd_cmd,
   output logic              rd_valid
);
   import cafp_pkg::*;

   cmd_type               slot_ff [CmdDepth];
   logic [CmdPtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CmdPtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CmdPtrW:0]      count_ff, count_in;

   assign full     = (count_ff == (CmdPtrW+1)'(CmdDepth));
   assign rd_valid = (count_ff != '0);
   assign rd_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + CmdPtrW'(wr_en);
      rd_ptr_in = rd_ptr_ff + CmdPtrW'(rd_en);
      count_in  = count_ff + (CmdPtrW+1)'(wr_en) - (CmdPtrW+1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

### hdl/cafp_front.sv
// Front end: marker registers, frame tracking and byte classification.
// Depends on cafp_pkg; feeds cafp_cmd_fifo.
module cafp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          fifo_full,
   input  logic                          csr_valid,
   input  logic [cafp_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [7:0]                    csr_wdata,
   output logic                          csr_ready,
   output logic                          enq,
   output cafp_pkg::cmd_type             enq_cmd
);
   import cafp_pkg::*;

   logic [7:0] start_marker_ff, start_marker_in;
   logic [7:0] end_marker_ff, end_marker_in;
   logic       in_frame_ff, in_frame_in;
   logic       accepted;
   logic       is_close;

   assign csr_ready = 1'b1;
   assign accepted  = push && !fifo_full;
   assign is_close  = (req_rx_byte == end_marker_ff);
   // bytes outside a frame never reach the back end
   assign enq       = accepted && in_frame_ff;

   always_comb begin
      enq_cmd.is_close = is_close;
      enq_cmd.cls      = classify(req_rx_byte);
      enq_cmd.digit    = 4'(req_rx_byte - CHR_ZERO);
   end

   always_comb begin
      start_marker_in = start_marker_ff;
      end_marker_in   = end_marker_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_MARKER: start_marker_in = csr_wdata;
            CSR_END_MARKER:   end_marker_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      if (accepted) begin
         if (!in_frame_ff) begin
            in_frame_in = (req_rx_byte == start_marker_ff);
         end else if (is_close) begin
            in_frame_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RST;
         end_marker_ff   <= END_MARKER_RST;
         in_frame_ff     <= 1'b0;
      end else begin
         start_marker_ff <= start_marker_in;
         end_marker_ff   <= end_marker_in;
         in_frame_ff     <= in_frame_in;
      end
   end

endmodule

### hdl/cafp_back.sv
// Back end: tokenizer and decimal reader, plus the two-word result queue.
// Depends on cafp_pkg; drains cafp_cmd_fifo.
module cafp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  cafp_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              pop,
   output logic              empty,
   output cafp_pkg::rsp_type rsp
);
   import cafp_pkg::*;

   logic [CntW-1:0]   count_ff, count_in;
   logic              text_ended_ff, text_ended_in;
   logic [FoundW-1:0] field_idx_ff, field_idx_in;
   logic              in_token_ff, in_token_in;
   phase_type         phase_ff, phase_in;
   logic              neg_ff, neg_in;
   logic [FieldW-1:0] acc_ff, acc_in;
   logic [FieldW-1:0] kept_ff [NumKept];
   logic [FieldW-1:0] kept_in [NumKept];

   rsp_type           rq_ff [RspDepth];
   logic [RspPtrW-1:0] rq_wr_ff, rq_rd_ff;
   logic [RspPtrW:0]  rq_cnt_ff, rq_cnt_in;
   logic              rq_full;
   logic              rq_push;
   logic              rq_pop;
   rsp_type           new_rsp;

   logic              active;
   logic [FieldW-1:0] tok_val;
   phase_type         ph;
   logic              ng;
   logic [FieldW-1:0] ac;
   logic [FieldW-1:0] vals [NumVals];
   logic [FoundW-1:0] found;

   assign rq_full = (rq_cnt_ff == (RspPtrW+1)'(RspDepth));
   assign empty   = (rq_cnt_ff == '0);
   assign rsp     = rq_ff[rq_rd_ff];
   assign rq_pop  = pop && !empty;

   // a close word waits for room in the result queue
   assign cmd_pop = cmd_valid && (!cmd.is_close || !rq_full);
   assign rq_push = cmd_pop && cmd.is_close;

   assign tok_val = neg_ff ? (FieldW'(0) - acc_ff) : acc_ff;
   assign active  = !text_ended_ff && (field_idx_ff < MaxFields) && (count_ff < PayloadLimit);

   // assemble the result for a close word
   always_comb begin
      for (int k = 0; k < NumKept; k++) begin
         vals[k] = kept_ff[k];
      end
      vals[NumVals-1] = '0;
      found = field_idx_ff;
      if (field_idx_ff == MaxFields) begin
         vals[NumVals-1] = tok_val;
      end else if (in_token_ff) begin
         vals[field_idx_ff] = tok_val;
         found = field_idx_ff + FoundW'(1);
      end
      new_rsp.module_code  = vals[0];
      new_rsp.op_code      = vals[1];
      new_rsp.arg_one      = vals[2];
      new_rsp.arg_two      = vals[3];
      new_rsp.arg_three    = vals[4];
      new_rsp.fields_found = found;
   end

   always_comb begin
      count_in      = count_ff;
      text_ended_in = text_ended_ff;
      field_idx_in  = field_idx_ff;
      in_token_in   = in_token_ff;
      phase_in      = phase_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      kept_in       = kept_ff;
      ph            = in_token_ff ? phase_ff : PH_SKIP;
      ng            = in_token_ff && neg_ff;
      ac            = in_token_ff ? acc_ff : '0;

      if (cmd_pop && cmd.is_close) begin
         count_in      = '0;
         text_ended_in = 1'b0;
         field_idx_in  = '0;
         in_token_in   = 1'b0;
         phase_in      = PH_SKIP;
         neg_in        = 1'b0;
         acc_in        = '0;
         for (int k = 0; k < NumKept; k++) begin
            kept_in[k] = '0;
         end
      end else if (cmd_pop && active) begin
         count_in = count_ff + CntW'(1);
         case (cmd.cls)
            CLS_NUL: text_ended_in = 1'b1;
            CLS_COLON: begin
               if (in_token_ff) begin
                  if (field_idx_ff <= LastKept) begin
                     kept_in[field_idx_ff[1:0]] = tok_val;
                  end
                  field_idx_in = field_idx_ff + FoundW'(1);
                  in_token_in  = 1'b0;
                  // the fifth token keeps its value for the close word
                  if (field_idx_ff != LastKept + FoundW'(1)) begin
                     phase_in = PH_SKIP;
                     neg_in   = 1'b0;
                     acc_in   = '0;
                  end
               end
            end
            default: begin
               in_token_in = 1'b1;
               if (ph == PH_SKIP) begin
                  if (cmd.cls inside {CLS_PLUS, CLS_MINUS}) begin
                     ng = (cmd.cls == CLS_MINUS);
                     ph = PH_DIGITS;
                  end else if (cmd.cls == CLS_SPACE) begin
                     ph = PH_SKIP;
                  end else if (cmd.cls == CLS_DIGIT) begin
                     ph = PH_DIGITS;
                     ac = FieldW'(cmd.digit);
                  end else begin
                     ph = PH_DONE;
                  end
               end else if (ph == PH_DIGITS) begin
                  if (cmd.cls == CLS_DIGIT) begin
                     ac = (ac << 3) + (ac << 1) + FieldW'(cmd.digit);
                  end else begin
                     ph = PH_DONE;
                  end
               end
               phase_in = ph;
               neg_in   = ng;
               acc_in   = ac;
            end
         endcase
      end
   end

   always_comb begin
      rq_cnt_in = rq_cnt_ff + (RspPtrW+1)'(rq_push) - (RspPtrW+1)'(rq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         text_ended_ff <= 1'b0;
         field_idx_ff  <= '0;
         in_token_ff   <= 1'b0;
         phase_ff      <= PH_SKIP;
         neg_ff        <= 1'b0;
         acc_ff        <= '0;
         for (int k = 0; k < NumKept; k++) begin
            kept_ff[k] <= '0;
         end
         rq_wr_ff      <= '0;
         rq_rd_ff      <= '0;
         rq_cnt_ff     <= '0;
      end else begin
         count_ff      <= count_in;
         text_ended_ff <= text_ended_in;
         field_idx_ff  <= field_idx_in;
         in_token_ff   <= in_token_in;
         phase_ff      <= phase_in;
         neg_ff        <= neg_in;
         acc_ff        <= acc_in;
         kept_ff       <= kept_in;
         rq_wr_ff      <= rq_wr_ff + RspPtrW'(rq_push);
         rq_rd_ff      <= rq_rd_ff + RspPtrW'(rq_pop);
         rq_cnt_ff     <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_ff[rq_wr_ff] <= new_rsp;
      end
   end

endmodule

### hdl/ascii_command_frame_parser_unit.sv
// Channel   | Ports                                  | Word accepted when
// ----------+----------------------------------------+--------------------------
// request   | push, full, req_rx_byte                | push && !full
// response  | empty, pop, rsp_* (5 values, found)    | pop && !empty
// csr write | csr_valid, csr_ready, csr_index/wdata  | csr_valid && csr_ready
//
// One byte per cycle sustained while full is low; a taken byte reaches the back end
// through the four-word byte queue, and a close byte's result is registered in the
// response queue. The back end retires one word per cycle unless a close word stalls.
// Reset is synchronous; afterwards markers are '>' and '<' and both queues are empty.
// full rises only when the response queue (two words) stays unread and the byte
// queue backs up behind a close word.
// Depends on cafp_pkg, cafp_front, cafp_cmd_fifo and cafp_back.
module ascii_command_frame_parser_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic [7:0]                           req_rx_byte,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [cafp_pkg::FieldW-1:0]   rsp_module_code,
   output logic signed [cafp_pkg::FieldW-1:0]   rsp_op_code,
   output logic signed [cafp_pkg::FieldW-1:0]   rsp_arg_one,
   output logic signed [cafp_pkg::FieldW-1:0]   rsp_arg_two,
   output logic signed [cafp_pkg::FieldW-1:0]   rsp_arg_three,
   output logic [cafp_pkg::FoundW-1:0]          rsp_fields_found,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cafp_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [7:0]                           csr_wdata
);
   import cafp_pkg::*;

   logic    enq;
   cmd_type enq_cmd;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;
   rsp_type rsp;

   cafp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_rx_byte (req_rx_byte),
      .fifo_full   (full),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .csr_ready   (csr_ready),
      .enq         (enq),
      .enq_cmd     (enq_cmd)
   );

   cafp_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (enq),
      .wr_cmd   (enq_cmd),
      .full     (full),
      .rd_en    (cmd_pop),
      .rd_cmd   (cmd),
      .rd_valid (cmd_valid)
   );

   cafp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp       (rsp)
   );

   assign rsp_module_code  = rsp.module_code;
   assign rsp_op_code      = rsp.op_code;
   assign rsp_arg_one      = rsp.arg_one;
   assign rsp_arg_two      = rsp.arg_two;
   assign rsp_arg_three    = rsp.arg_three;
   assign rsp_fields_found = rsp.fields_found;

endmodule

### hdl/cafp_checker.sv
// Port-level checks for ascii_command_frame_parser_unit, attached by bind.
// Depends on cafp_pkg.
module cafp_port_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 push,
   input logic                                 full,
   input logic [7:0]                           req_rx_byte,
   input logic                                 empty,
   input logic                                 pop,
   input logic signed [cafp_pkg::FieldW-1:0]   rsp_module_code,
   input logic signed [cafp_pkg::FieldW-1:0]   rsp_op_code,
   input logic signed [cafp_pkg::FieldW-1:0]   rsp_arg_one,
   input logic signed [cafp_pkg::FieldW-1:0]   rsp_arg_two,
   input logic signed [cafp_pkg::FieldW-1:0]   rsp_arg_three,
   input logic [cafp_pkg::FoundW-1:0]          rsp_fields_found,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [cafp_pkg::CsrIdxW-1:0]         csr_index,
   input logic [7:0]                           csr_wdata
);
   import cafp_pkg::*;

   // both queues come out of reset empty
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // a waiting result word holds until popped
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_module_code) && $stable(rsp_op_code)
         && $stable(rsp_arg_one) && $stable(rsp_arg_two) && $stable(rsp_arg_three)
         && $stable(rsp_fields_found)))
      else $error("result word changed while stalled");

   a_found_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_fields_found <= MaxFields))
      else $error("fields_found out of range");

   // fields past the found count read as zero (checked for arg_three and module_code)
   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_fields_found == MaxFields || rsp_arg_three == '0)
         && (rsp_fields_found != '0 || rsp_module_code == '0)))
      else $error("missing field not zero");

   // a result cannot appear right out of reset
   a_rsp_needs_input: assert property (@(posedge clock) disable iff (reset)
      ($past(empty) && !empty && !$past(reset)) |-> !$past(reset, 2))
      else $error("result appeared right out of reset");

endmodule

bind ascii_command_frame_parser_unit cafp_port_checker u_cafp_checker (.*);

### verif/cafp_checker.sv
// Command checker for the ASCII frame parser: tracks markers, parses accepted bytes
// into expected command words and compares every popped response word with them.
// Depends on cafp_pkg for field widths, character codes and the response struct.
module cafp_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  logic                                 full,
   input  logic [7:0]                           req_rx_byte,
   input  logic                                 empty,
   input  logic                                 pop,
   input  logic signed [cafp_pkg::FieldW-1:0]   rsp_module_code,
   input  logic signed [cafp_pkg::FieldW-1:0]   rsp_op_code,
   input  logic signed [cafp_pkg::FieldW-1:0]   rsp_arg_one,
   input  logic signed [cafp_pkg::FieldW-1:0]   rsp_arg_two,
   input  logic signed [cafp_pkg::FieldW-1:0]   rsp_arg_three,
   input  logic [cafp_pkg::FoundW-1:0]          rsp_fields_found,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [cafp_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [7:0]                           csr_wdata,
   output int unsigned                          errors,
   output int unsigned                          outstanding
);
   import cafp_pkg::*;

   localparam int ShowMax = 10;

   logic [7:0]        open_mk;
   logic [7:0]        close_mk;
   logic              frame_open;
   int                pay_cnt;
   logic              text_done;
   logic [FoundW-1:0] tok_idx;
   logic              tok_open;
   phase_type         num_phase;
   logic              num_neg;
   logic [FieldW-1:0] num_acc;
   logic [FieldW-1:0] kept_vals [NumKept];
   rsp_type           cmd_queue [$];
   int unsigned       fail_count = 0;

   function automatic logic is_blank(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic [FieldW-1:0] token_value();
      return num_neg ? FieldW'(~num_acc + 16'd1) : num_acc;
   endfunction

   function automatic void clear_frame();
      frame_open = 1'b0;
      pay_cnt    = 0;
      text_done  = 1'b0;
      tok_idx    = '0;
      tok_open   = 1'b0;
      num_phase  = PH_SKIP;
      num_neg    = 1'b0;
      num_acc    = '0;
      foreach (kept_vals[k]) kept_vals[k] = '0;
   endfunction

   function automatic void take_payload(input logic [7:0] b);
      if (text_done || tok_idx >= MaxFields) return;
      if (pay_cnt >= BUFFER_BYTES - 1) return;
      pay_cnt++;
      if (b == 8'h00) begin
         text_done = 1'b1;
         return;
      end
      if (b == CHR_COLON) begin
         // separator runs collapse: only a colon after a token closes it
         if (tok_open) begin
            if (tok_idx <= LastKept) kept_vals[tok_idx] = token_value();
            tok_idx++;
            tok_open = 1'b0;
            if (tok_idx < MaxFields) begin
               num_phase = PH_SKIP;
               num_neg   = 1'b0;
               num_acc   = '0;
            end
         end
         return;
      end
      if (!tok_open) begin
         tok_open  = 1'b1;
         num_phase = PH_SKIP;
         num_neg   = 1'b0;
         num_acc   = '0;
      end
      if (num_phase == PH_SKIP) begin
         if (is_blank(b)) return;
         if (b == CHR_PLUS || b == CHR_MINUS) begin
            num_neg   = (b == CHR_MINUS);
            num_phase = PH_DIGITS;
            return;
         end
         num_phase = PH_DIGITS;
      end
      if (num_phase == PH_DIGITS) begin
         if (b >= CHR_ZERO && b <= CHR_ZERO + 8'd9)
            num_acc = FieldW'(num_acc * 16'd10 + {12'd0, b[3:0]});
         else
            num_phase = PH_DONE;
      end
   endfunction

   function automatic void close_frame();
      logic [FieldW-1:0] vals [NumVals];
      int                count;
      rsp_type           cmd;
      foreach (vals[k]) vals[k] = '0;
      count = int'(tok_idx);
      for (int k = 0; k < count && k < NumKept; k++) vals[k] = kept_vals[k];
      // fifth token stays live in the number state, it is never stored
      if (count == NumVals) begin
         vals[NumVals-1] = token_value();
      end else if (tok_open) begin
         vals[count] = token_value();
         count++;
      end
      cmd.module_code  = vals[0];
      cmd.op_code      = vals[1];
      cmd.arg_one      = vals[2];
      cmd.arg_two      = vals[3];
      cmd.arg_three    = vals[4];
      cmd.fields_found = FoundW'(count);
      cmd_queue.push_back(cmd);
      clear_frame();
   endfunction

   function automatic void parse_byte(input logic [7:0] b);
      if (!frame_open) begin
         if (b == open_mk) begin
            clear_frame();
            frame_open = 1'b1;
         end
      end else if (b != close_mk) begin
         take_payload(b);
      end else begin
         close_frame();
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      logic    bad;
      if (reset) begin
         open_mk  = START_MARKER_RST;
         close_mk = END_MARKER_RST;
         clear_frame();
         cmd_queue.delete();
      end else begin
         if (pop && !empty) begin
            got.module_code  = rsp_module_code;
            got.op_code      = rsp_op_code;
            got.arg_one      = rsp_arg_one;
            got.arg_two      = rsp_arg_two;
            got.arg_three    = rsp_arg_three;
            got.fields_found = rsp_fields_found;
            if (cmd_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= ShowMax)
                  $display("unexpected command word: %0d %0d %0d %0d %0d found %0d",
                           got.module_code, got.op_code, got.arg_one, got.arg_two,
                           got.arg_three, got.fields_found);
            end else begin
               want = cmd_queue.pop_front();
               bad = (got.module_code !== want.module_code) ||
                     (got.op_code !== want.op_code) ||
                     (got.arg_one !== want.arg_one) ||
                     (got.arg_two !== want.arg_two) ||
                     (got.arg_three !== want.arg_three) ||
                     (got.fields_found !== want.fields_found);
               if (bad) begin
                  fail_count++;
                  if (fail_count <= ShowMax)
                     $display("command word differs: exp %0d %0d %0d %0d %0d found %0d, %s",
                              want.module_code, want.op_code, want.arg_one,
                              want.arg_two, want.arg_three, want.fields_found,
                              $sformatf("got %0d %0d %0d %0d %0d found %0d",
                                        got.module_code, got.op_code, got.arg_one,
                                        got.arg_two, got.arg_three, got.fields_found));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_START_MARKER) open_mk = csr_wdata;
            else if (csr_index == CSR_END_MARKER) close_mk = csr_wdata;
         end
         if (push && !full) parse_byte(req_rx_byte);
      end
      outstanding <= cmd_queue.size();
      errors      <= fail_count;
   end

endmodule

### verif/tb_ascii_command_frame_parser_unit.sv
// Top of the frame parser testbench: clock, reset, byte and register stimulus,
// response popping with stalls, watchdog and verdict.
// Depends on cafp_pkg, ascii_command_frame_parser_unit and cafp_checker.
module tb_ascii_command_frame_parser_unit;
   import cafp_pkg::*;

   localparam int HalfPeriod = 4;
   localparam int WatchLimit = 5000;
   localparam int SettleCycles = 16;
   localparam int PhaseBytes = 375;
   localparam int HoldOff = 300;
   localparam logic [CsrIdxW-1:0] CSR_PAST_LAST = CSR_END_MARKER + 8'd1;
   localparam logic [CsrIdxW-1:0] CSR_TOP_INDEX = '1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic [7:0]           req_rx_byte = 8'h00;
   logic                 pop = 1'b0;
   logic                 csr_valid = 1'b0;
   logic [CsrIdxW-1:0]   csr_index = '0;
   logic [7:0]           csr_wdata = 8'h00;
   logic                 full;
   logic                 empty;
   logic                 csr_ready;
   logic signed [FieldW-1:0] rsp_module_code;
   logic signed [FieldW-1:0] rsp_op_code;
   logic signed [FieldW-1:0] rsp_arg_one;
   logic signed [FieldW-1:0] rsp_arg_two;
   logic signed [FieldW-1:0] rsp_arg_three;
   logic [FoundW-1:0]    rsp_fields_found;
   int unsigned          errors;
   int unsigned          outstanding;

   int                   send_idle = 0;
   int                   recv_stall = 0;
   int                   hold_cycles = 0;
   int                   quiet_run = 0;
   int                   bytes_sent = 0;
   logic [7:0]           start_mk = START_MARKER_RST;
   logic [7:0]           end_mk = END_MARKER_RST;

   always #HalfPeriod clock = ~clock;

   ascii_command_frame_parser_unit dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_rx_byte      (req_rx_byte),
      .empty            (empty),
      .pop              (pop),
      .rsp_module_code  (rsp_module_code),
      .rsp_op_code      (rsp_op_code),
      .rsp_arg_one      (rsp_arg_one),
      .rsp_arg_two      (rsp_arg_two),
      .rsp_arg_three    (rsp_arg_three),
      .rsp_fields_found (rsp_fields_found),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   cafp_checker cmd_check (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_rx_byte      (req_rx_byte),
      .empty            (empty),
      .pop              (pop),
      .rsp_module_code  (rsp_module_code),
      .rsp_op_code      (rsp_op_code),
      .rsp_arg_one      (rsp_arg_one),
      .rsp_arg_two      (rsp_arg_two),
      .rsp_arg_three    (rsp_arg_three),
      .rsp_fields_found (rsp_fields_found),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .errors           (errors),
      .outstanding      (outstanding)
   );

   // entered just after a rising edge; leaves push high after the accepting edge
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push        <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic string extreme_text(input int k);
      case (k)
         0: return "32767";
         1: return "-32768";
         2: return "65535";
         3: return "65536";
         4: return "0";
         5: return "-0";
         default: return "99999";
      endcase
   endfunction

   task automatic send_token();
      int k;
      if ($urandom_range(9) < 2) begin
         repeat ($urandom_range(1, 2)) begin
            k = $urandom_range(0, 5);
            send_byte(k == 5 ? 8'h20 : 8'h09 + 8'(k));
         end
      end
      if ($urandom_range(99) < 12) begin
         send_text(extreme_text($urandom_range(0, 6)));
      end else begin
         if ($urandom_range(99) < 30) send_byte($urandom_range(1) ? CHR_MINUS : CHR_PLUS);
         repeat ($urandom_range(0, 6)) send_byte(CHR_ZERO + 8'($urandom_range(9)));
      end
      if ($urandom_range(99) < 10) send_byte(8'($urandom_range(255)));
   endtask

   // mostly well-formed frames; some noise and some frames left unclosed
   task automatic send_frame();
      int kind;
      int ntok;
      kind = $urandom_range(99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
         return;
      end
      send_byte(start_mk);
      if ($urandom_range(9) == 0) send_byte(CHR_COLON);
      ntok = $urandom_range(0, 7);
      for (int k = 0; k < ntok; k++) begin
         if (k > 0) repeat ($urandom_range(9) == 0 ? 3 : 1) send_byte(CHR_COLON);
         send_token();
      end
      if ($urandom_range(9) == 0) send_byte(CHR_COLON);
      if ($urandom_range(19) == 0) begin
         send_byte(8'h00);
         send_token();
      end
      if ($urandom_range(14) == 0)
         repeat ($urandom_range(20, 40)) send_byte(CHR_ZERO + 8'($urandom_range(9)));
      if (kind >= 14) send_byte(end_mk);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_START_MARKER) start_mk = val;
      else if (idx == CSR_END_MARKER) end_mk = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop sending, wait for all commands, then let non-closing bytes drain
   task automatic settle();
      @(negedge clock);
      push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   initial begin : receiver
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready))
         quiet_run = 0;
      else
         quiet_run++;
      if (quiet_run >= WatchLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      int quota;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_text("ab<9");
      send_text(">1:2:3:4:5<");
      send_text("> \t-12: +34 ::99999:-32768:32767:6:7<");
      send_text("><");
      send_text(">::7a:b:<");
      send_text(">1");
      send_byte(8'h00);
      send_text("2:3<");
      send_text(">>");
      send_byte(8'h80);
      send_byte(8'hFF);
      send_text("+-5:\r65535<");
      // frame stays open across the marker change
      send_text(">12:3");
      settle();
      write_reg(CSR_START_MARKER, 8'h00);
      write_reg(CSR_END_MARKER, 8'hFF);
      write_reg(CSR_PAST_LAST, 8'h41);
      write_reg(CSR_TOP_INDEX, 8'h42);
      send_text(":4");
      send_byte(8'hFF);
      send_byte(8'h00);
      send_text("-1:2");
      send_byte(8'hFF);
      settle();
      write_reg(CSR_START_MARKER, START_MARKER_RST);
      write_reg(CSR_END_MARKER, END_MARKER_RST);

      // long receiver hold-off so both queues fill and full rises
      hold_cycles = HoldOff;
      repeat (24) send_text(">1<");
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: begin
               write_reg(CSR_START_MARKER, 8'h00);
               write_reg(CSR_END_MARKER, 8'hFF);
               send_idle  = 58;
               recv_stall = 0;
            end
            2: begin
               write_reg(CSR_START_MARKER, 8'hFF);
               write_reg(CSR_END_MARKER, 8'h00);
               send_idle  = 0;
               recv_stall = 58;
            end
            3: begin
               // equal markers: opens outside a frame, closes inside
               write_reg(CSR_START_MARKER, 8'h7C);
               write_reg(CSR_END_MARKER, 8'h7C);
               send_idle  = 37;
               recv_stall = 37;
            end
            default: begin
               send_idle  = 0;
               recv_stall = 0;
            end
         endcase
         quota = bytes_sent + PhaseBytes;
         while (bytes_sent < quota) send_frame();
         settle();
      end

      if (errors == 0 && outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
